// ===== rtl/gds_pkg.sv =====
`default_nettype none

package gds_pkg;

    // field widths
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int CNT_W  = 16;
    localparam int WD_W   = 3;
    localparam int YMOD_W = 9;   // year mod 400
    localparam int Q_W    = 6;   // year / 400 for a 14-bit year plus 400
    localparam int SUM_W  = 16;  // weekday accumulator before mod 7

    // parameter defaults
    localparam int YEAR_MAX_DEF   = 9999;
    localparam int COUNT_BITS_DEF = 16;

    // y / 400 == (y * RECIP_400) >> RECIP_SH, exact for y < 2^15
    localparam int RECIP_400 = 5243;
    localparam int RECIP_SH  = 21;
    localparam int PROD_W    = 27;

    localparam logic [YMOD_W-1:0] YMOD_LAST = YMOD_W'(399);

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_MAR = MON_W'(3);
    localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
    localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
    localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
    localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAY_LAST  = DAY_W'(31);

    typedef enum logic [1:0] {
        OP_NEXT = 2'd0,
        OP_PREV = 2'd1,
        OP_ADD  = 2'd2,
        OP_SUB  = 2'd3
    } t_op;

    // result of one day step
    typedef struct packed {
        logic              ok;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic              yr_inc;
        logic              yr_dec;
        logic [YMOD_W-1:0] ymod;
    } t_step;

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic div4;
        logic cent;
        div4 = (ymod[1:0] == 2'd0);
        cent = (ymod == YMOD_W'(100)) || (ymod == YMOD_W'(200)) || (ymod == YMOD_W'(300));
        return div4 && !cent;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = DAY_W'(30);
        end else if (m == MON_FEB) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

    // floor(23 * m / 9)
    function automatic logic [DAY_W-1:0] kc_month_term(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] t;
        case (m)
            4'd1:    t = DAY_W'(2);
            4'd2:    t = DAY_W'(5);
            4'd3:    t = DAY_W'(7);
            4'd4:    t = DAY_W'(10);
            4'd5:    t = DAY_W'(12);
            4'd6:    t = DAY_W'(15);
            4'd7:    t = DAY_W'(17);
            4'd8:    t = DAY_W'(20);
            4'd9:    t = DAY_W'(23);
            4'd10:   t = DAY_W'(25);
            4'd11:   t = DAY_W'(28);
            4'd12:   t = DAY_W'(30);
            default: t = DAY_W'(0);
        endcase
        return t;
    endfunction

    // r / 100 for r < 400
    function automatic logic [1:0] div100(input logic [YMOD_W-1:0] r);
        logic [1:0] q;
        if (r >= YMOD_W'(300))      q = 2'd3;
        else if (r >= YMOD_W'(200)) q = 2'd2;
        else if (r >= YMOD_W'(100)) q = 2'd1;
        else                        q = 2'd0;
        return q;
    endfunction

    // mod 7 by folding octal digits (8 == 1 mod 7)
    function automatic logic [WD_W-1:0] mod7(input logic [SUM_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        if (s2 >= 4'd14)     r = s2 - 4'd14;
        else if (s2 >= 4'd7) r = s2 - 4'd7;
        else                 r = s2;
        return r[WD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gregorian_date_stepper.sv =====
// Gregorian date stepper.
// Input channel (i_valid / o_ready): one beat carries an opcode (next day,
// previous day, add or subtract i_day_count days) and a starting date.
// Output channel (o_valid / i_ready): one beat per input beat, carrying the
// resulting date, its weekday (0 = Sunday) and o_range_error. On a range
// error the (clamped) starting date and its weekday come back unchanged.
// Setup runs year / 400 via one reciprocal multiply, year mod 400, day
// clamp, weekday sum and mod 7 in turn; then the walk takes one step per
// day and the result is registered as the walk ends. A walk that leaves
// the year range stops once the failing step has set the error flag.
// o_ready rises as the result is registered, so a new date is taken only
// after the previous walk has ended; the walk through the one-day step
// unit sets the pace while the receiver keeps up.
// The result sits in an output register, so the next beat is taken while it
// waits; if the receiver still stalls when the next walk ends, the sequencer
// holds in its last state until the output register frees.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; nothing else needs clearing.
`default_nettype none

module gregorian_date_stepper #(
    parameter int YEAR_MAX   = gds_pkg::YEAR_MAX_DEF,
    parameter int COUNT_BITS = gds_pkg::COUNT_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [gds_pkg::DAY_W-1:0]  i_day_in,
    input  wire logic [gds_pkg::MON_W-1:0]  i_month_in,
    input  wire logic [gds_pkg::YEAR_W-1:0] i_year_in,
    input  wire logic [gds_pkg::CNT_W-1:0]  i_day_count,

    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [gds_pkg::DAY_W-1:0]      o_day_out,
    output logic [gds_pkg::MON_W-1:0]      o_month_out,
    output logic [gds_pkg::YEAR_W-1:0]     o_year_out,
    output logic [gds_pkg::WD_W-1:0]       o_weekday,
    output logic                           o_range_error
);

    // only the low min(COUNT_BITS, 16) bits of the 16-bit count are used
    localparam int CW     = (COUNT_BITS < gds_pkg::CNT_W) ? COUNT_BITS : gds_pkg::CNT_W;
    // walking year must hold YEAR_MAX as well as any 14-bit input year
    localparam int YMAX_W = $clog2(YEAR_MAX + 1);
    localparam int YR_W   = (YMAX_W > gds_pkg::YEAR_W) ? YMAX_W : gds_pkg::YEAR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MODR,
        S_CLAMP,
        S_WD1,
        S_WD2,
        S_WALK
    } t_state;

    t_state                      r_state;
    logic                        r_back;
    logic [CW-1:0]               r_cnt;
    logic                        r_err;
    logic [gds_pkg::DAY_W-1:0]   r_d0;
    logic [gds_pkg::MON_W-1:0]   r_m0;
    logic [gds_pkg::YEAR_W-1:0]  r_y0;
    logic [gds_pkg::Q_W-1:0]     r_q;
    logic [gds_pkg::YMOD_W-1:0]  r_ymod;
    logic [gds_pkg::SUM_W-1:0]   r_sum;
    logic [gds_pkg::WD_W-1:0]    r_wd0;
    logic [gds_pkg::DAY_W-1:0]   r_d;
    logic [gds_pkg::MON_W-1:0]   r_m;
    logic [YR_W-1:0]             r_y;
    logic [gds_pkg::WD_W-1:0]    r_wd;

    logic                        r_ov;
    logic [gds_pkg::DAY_W-1:0]   r_o_day;
    logic [gds_pkg::MON_W-1:0]   r_o_month;
    logic [gds_pkg::YEAR_W-1:0]  r_o_year;
    logic [gds_pkg::WD_W-1:0]    r_o_wd;
    logic                        r_o_err;

    gds_pkg::t_op                in_op;
    logic [gds_pkg::MON_W-1:0]   in_month;
    logic [gds_pkg::PROD_W-1:0]  prod;
    logic [gds_pkg::YEAR_W:0]    q_times_400;
    logic [gds_pkg::YEAR_W-1:0]  ymod_wide;
    logic [gds_pkg::DAY_W-1:0]   len0;
    logic [gds_pkg::Q_W-1:0]     wd_q;
    logic [gds_pkg::YMOD_W-1:0]  wd_r;
    logic                        early;       // January or February
    logic [gds_pkg::SUM_W-1:0]   n_sum;
    gds_pkg::t_step              step;
    logic                        out_free;
    logic                        walk_done;

    assign in_op = gds_pkg::t_op'(i_opcode);

    // month clamp into 1..12
    always_comb begin
        if (i_month_in == '0)                  in_month = gds_pkg::MON_JAN;
        else if (i_month_in > gds_pkg::MON_DEC) in_month = gds_pkg::MON_DEC;
        else                                   in_month = i_month_in;
    end

    // year / 400 by reciprocal multiply, registered into r_q
    assign prod = gds_pkg::PROD_W'(r_y0) * gds_pkg::PROD_W'(gds_pkg::RECIP_400);
    assign q_times_400 = (gds_pkg::YEAR_W+1)'(r_q) * (gds_pkg::YEAR_W+1)'(400);
    assign ymod_wide   = r_y0 - q_times_400[gds_pkg::YEAR_W-1:0];

    assign len0 = gds_pkg::month_len(r_m0, gds_pkg::is_leap(r_ymod));

    // Keith-Craver: Y = y + 399 for Jan/Feb, y + 400 otherwise; split Y into
    // 400 * wd_q + wd_r from the year's own quotient and remainder
    assign early = (r_m0 < gds_pkg::MON_MAR);
    always_comb begin
        if (early && r_ymod == '0) begin
            wd_q = r_q;
            wd_r = gds_pkg::YMOD_LAST;
        end else if (early) begin
            wd_q = r_q + gds_pkg::Q_W'(1);
            wd_r = r_ymod - gds_pkg::YMOD_W'(1);
        end else begin
            wd_q = r_q + gds_pkg::Q_W'(1);
            wd_r = r_ymod;
        end
    end

    // d + 23m/9 + y + 4 + day shift + Y/4 - Y/100 + Y/400, with
    // Y/4 - Y/100 + Y/400 = 97*q + r/4 - r/100
    assign n_sum = gds_pkg::SUM_W'(gds_pkg::kc_month_term(r_m0))
                 + gds_pkg::SUM_W'(r_d0)
                 + gds_pkg::SUM_W'(4)
                 + gds_pkg::SUM_W'(r_y0)
                 + (early ? gds_pkg::SUM_W'(400) : gds_pkg::SUM_W'(398))
                 + gds_pkg::SUM_W'(wd_q) * gds_pkg::SUM_W'(97)
                 + gds_pkg::SUM_W'(wd_r[gds_pkg::YMOD_W-1:2])
                 - gds_pkg::SUM_W'(gds_pkg::div100(wd_r));

    gds_step_unit #(
        .YR_W     (YR_W),
        .YEAR_MAX (YEAR_MAX)
    ) u_step (
        .i_back  (r_back),
        .i_day   (r_d),
        .i_month (r_m),
        .i_year  (r_y),
        .i_ymod  (r_ymod),
        .o_res   (step)
    );

    assign out_free  = !r_ov || i_ready;
    assign walk_done = r_err || (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // a finishing walk refills the output register as it drains
            if ((r_state == S_WALK) && walk_done && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_back  <= (in_op == gds_pkg::OP_PREV) || (in_op == gds_pkg::OP_SUB);
                        r_cnt   <= (in_op == gds_pkg::OP_ADD || in_op == gds_pkg::OP_SUB)
                                 ? i_day_count[CW-1:0] : CW'(1);
                        r_d0    <= i_day_in;
                        r_m0    <= in_month;
                        r_y0    <= i_year_in;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_q     <= prod[gds_pkg::RECIP_SH +: gds_pkg::Q_W];
                    r_state <= S_MODR;
                end
                S_MODR: begin
                    r_ymod  <= ymod_wide[gds_pkg::YMOD_W-1:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    // day clamp into 1..length of month
                    if (r_d0 == '0)       r_d0 <= gds_pkg::DAY_FIRST;
                    else if (r_d0 > len0) r_d0 <= len0;
                    r_state <= S_WD1;
                end
                S_WD1: begin
                    r_sum   <= n_sum;
                    r_d     <= r_d0;
                    r_m     <= r_m0;
                    r_y     <= YR_W'(r_y0);
                    r_err   <= (YR_W'(r_y0) > YR_W'(YEAR_MAX));
                    r_state <= S_WD2;
                end
                S_WD2: begin
                    r_wd0   <= gds_pkg::mod7(r_sum);
                    r_wd    <= gds_pkg::mod7(r_sum);
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (walk_done) begin
                        if (out_free) begin
                            r_o_err   <= r_err;
                            r_o_day   <= r_err ? r_d0 : r_d;
                            r_o_month <= r_err ? r_m0 : r_m;
                            r_o_year  <= r_err ? r_y0 : r_y[gds_pkg::YEAR_W-1:0];
                            r_o_wd    <= r_err ? r_wd0 : r_wd;
                            r_state   <= S_IDLE;
                        end
                    end else if (!step.ok) begin
                        // left the year range; r_err ends the walk, which returns the clamped input date
                        r_err <= 1'b1;
                    end else begin
                        r_d    <= step.day;
                        r_m    <= step.month;
                        r_ymod <= step.ymod;
                        if (step.yr_inc)      r_y <= r_y + YR_W'(1);
                        else if (step.yr_dec) r_y <= r_y - YR_W'(1);
                        if (r_back) begin
                            r_wd <= (r_wd == '0) ? gds_pkg::WD_W'(6) : r_wd - gds_pkg::WD_W'(1);
                        end else begin
                            r_wd <= (r_wd == gds_pkg::WD_W'(6)) ? '0 : r_wd + gds_pkg::WD_W'(1);
                        end
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_day_out     = r_o_day;
    assign o_month_out   = r_o_month;
    assign o_year_out    = r_o_year;
    assign o_weekday     = r_o_wd;
    assign o_range_error = r_o_err;

endmodule

`default_nettype wire

// ===== rtl/gds_step_unit.sv =====
`default_nettype none

// One calendar day forward or back; the shared unit of the walk.
module gds_step_unit #(
    parameter int YR_W     = gds_pkg::YEAR_W,
    parameter int YEAR_MAX = gds_pkg::YEAR_MAX_DEF
) (
    input  wire logic                       i_back,
    input  wire logic [gds_pkg::DAY_W-1:0]  i_day,
    input  wire logic [gds_pkg::MON_W-1:0]  i_month,
    input  wire logic [YR_W-1:0]            i_year,
    input  wire logic [gds_pkg::YMOD_W-1:0] i_ymod,
    output gds_pkg::t_step                  o_res
);

    logic                      leap;
    logic [gds_pkg::DAY_W-1:0] len_cur;
    logic [gds_pkg::DAY_W-1:0] len_prev;
    logic [gds_pkg::MON_W-1:0] month_prev;

    assign leap       = gds_pkg::is_leap(i_ymod);
    assign len_cur    = gds_pkg::month_len(i_month, leap);
    assign month_prev = i_month - gds_pkg::MON_W'(1);
    assign len_prev   = gds_pkg::month_len(month_prev, leap);

    always_comb begin
        o_res.ok     = 1'b1;
        o_res.day    = i_day;
        o_res.month  = i_month;
        o_res.yr_inc = 1'b0;
        o_res.yr_dec = 1'b0;
        o_res.ymod   = i_ymod;
        if (!i_back) begin
            if (i_day < len_cur) begin
                o_res.day = i_day + gds_pkg::DAY_W'(1);
            end else if (i_month < gds_pkg::MON_DEC) begin
                o_res.day   = gds_pkg::DAY_FIRST;
                o_res.month = i_month + gds_pkg::MON_W'(1);
            end else if (i_year >= YR_W'(YEAR_MAX)) begin
                o_res.ok = 1'b0;
            end else begin
                o_res.day    = gds_pkg::DAY_FIRST;
                o_res.month  = gds_pkg::MON_JAN;
                o_res.yr_inc = 1'b1;
                o_res.ymod   = (i_ymod == gds_pkg::YMOD_LAST) ? '0
                             : i_ymod + gds_pkg::YMOD_W'(1);
            end
        end else begin
            if (i_day > gds_pkg::DAY_FIRST) begin
                o_res.day = i_day - gds_pkg::DAY_W'(1);
            end else if (i_month > gds_pkg::MON_JAN) begin
                o_res.month = month_prev;
                o_res.day   = len_prev;
            end else if (i_year == '0) begin
                o_res.ok = 1'b0;
            end else begin
                o_res.day    = gds_pkg::DAY_LAST;
                o_res.month  = gds_pkg::MON_DEC;
                o_res.yr_dec = 1'b1;
                o_res.ymod   = (i_ymod == '0) ? gds_pkg::YMOD_LAST
                             : i_ymod - gds_pkg::YMOD_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
